// ----- rtl/qbez_pkg.sv -----
`default_nettype none

package qbez_pkg;

  localparam int NUM_POINTS = 5;
  localparam int COORD_W    = 16;
  localparam int POINT_W    = 2 * COORD_W;
  localparam int T_W        = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_LANES  = 2;

  localparam logic [CFG_IDX_W-1:0] IDX_POINT_ZERO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] IDX_POINT_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] IDX_POINT_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_POINT_THREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] IDX_POINT_FOUR  = 3'd4;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7fff;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;

  typedef logic [POINT_W-1:0] point_t;
  typedef logic signed [COORD_W-1:0] coord_t;

endpackage

`default_nettype wire

// ----- rtl/qbez_if.sv -----
`default_nettype none

interface qbez_t_if;
  logic                      valid;
  logic                      ready;
  logic [qbez_pkg::T_W-1:0]  t_value;

  modport source (output valid, output t_value, input ready);
  modport sink   (input valid, input t_value, output ready);
endinterface

interface qbez_xy_if;
  logic               valid;
  logic               ready;
  qbez_pkg::coord_t   x_coord;
  qbez_pkg::coord_t   y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

`default_nettype wire

// ----- rtl/qbez_rnd_mul.sv -----
`default_nettype none

module qbez_rnd_mul #(
  parameter int FRAC_BITS = 15
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic [FRAC_BITS:0]   a_i,
  input  wire logic [FRAC_BITS:0]   b_i,
  output      logic [FRAC_BITS:0]   p_o
);

  localparam int W  = FRAC_BITS + 1;
  localparam int PW = 2 * W;
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  logic [PW-1:0] prod;
  logic [PW-1:0] prod_rnd;
  logic [W-1:0]  p_q;

  // operands never exceed one, so the rounded result fits in W bits
  assign prod     = PW'(a_i) * PW'(b_i);
  assign prod_rnd = prod + HALF;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= prod_rnd[FRAC_BITS +: W];
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ----- rtl/quartic_bezier_point_eval.sv -----
`default_nettype none

// Quartic Bezier point evaluator: takes one t beat per cycle (unsigned, FRAC_BITS
// fraction bits, values above one act as one) and returns the curve point x, y,
// rounded half up and saturated to 16-bit signed. Sustained rate is one point per
// clock while the output is ready; stages are a clamp stage, the chain of rounded
// multiplies that builds t^4 and (1-t)^4 (three stages), the point-times-weight
// multiply stage and a two-stage adder tree with rounding. Stages hold their data
// under backpressure and bubbles are squeezed out, so the input stays ready until
// all seven stages hold a beat. The user must write control points through the cfg
// port while no beat is in flight (not enforced); index values above four are ignored.
module quartic_bezier_point_eval #(
  parameter int FRAC_BITS = 15
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [qbez_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [qbez_pkg::POINT_W-1:0]   cfg_data_i,
  qbez_t_if.sink                              t_i,
  qbez_xy_if.source                           pt_o
);

  localparam int W   = FRAC_BITS + 1;
  localparam int TIW = (W > qbez_pkg::T_W) ? W : qbez_pkg::T_W;
  localparam int BW  = W + 3;
  localparam int PW  = qbez_pkg::COORD_W + BW + 1;
  localparam int AW  = PW + 3;
  localparam int QW  = AW - FRAC_BITS;
  localparam int NS  = 7;
  localparam int NP  = qbez_pkg::NUM_POINTS;
  localparam int NL  = qbez_pkg::NUM_LANES;

  localparam logic [W-1:0]          ONE      = W'(1) << FRAC_BITS;
  localparam logic [TIW-1:0]        ONE_X    = TIW'(1) << FRAC_BITS;
  localparam logic signed [AW-1:0]  HALF_ACC = AW'(1) << (FRAC_BITS - 1);
  localparam logic signed [QW-1:0]  Q_MAX    = QW'(qbez_pkg::COORD_MAX);
  localparam logic signed [QW-1:0]  Q_MIN    = QW'(qbez_pkg::COORD_MIN);

  qbez_pkg::point_t point_q [NP];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NP; i++) begin
        point_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qbez_pkg::IDX_POINT_ZERO:  point_q[0] <= cfg_data_i;
        qbez_pkg::IDX_POINT_ONE:   point_q[1] <= cfg_data_i;
        qbez_pkg::IDX_POINT_TWO:   point_q[2] <= cfg_data_i;
        qbez_pkg::IDX_POINT_THREE: point_q[3] <= cfg_data_i;
        qbez_pkg::IDX_POINT_FOUR:  point_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control: a stage loads when empty or when it hands its beat on
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || pt_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= t_i.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign t_i.ready  = en[0];
  assign pt_o.valid = v_q[NS-1];

  // stage 0: clamp t, form s = 1 - t
  logic [TIW-1:0] t_ext;
  logic [W-1:0]   t_clamp;
  logic [W-1:0]   t0_q, s0_q;

  assign t_ext   = TIW'(t_i.t_value);
  assign t_clamp = (t_ext > ONE_X) ? ONE : t_ext[W-1:0];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      t0_q <= t_clamp;
      s0_q <= ONE - t_clamp;
    end
  end

  // stage 1: squares
  logic [W-1:0] t1_q, s1_q, t2, s2;

  qbez_rnd_mul #(.FRAC_BITS(FRAC_BITS)) u_t2 (
    .clk_i, .en_i(en[1]), .a_i(t0_q), .b_i(t0_q), .p_o(t2)
  );
  qbez_rnd_mul #(.FRAC_BITS(FRAC_BITS)) u_s2 (
    .clk_i, .en_i(en[1]), .a_i(s0_q), .b_i(s0_q), .p_o(s2)
  );

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      t1_q <= t0_q;
      s1_q <= s0_q;
    end
  end

  // stage 2: cubes and the middle cross term
  logic [W-1:0] t2p_q, s2p_q, t3, s3, q2;

  qbez_rnd_mul #(.FRAC_BITS(FRAC_BITS)) u_t3 (
    .clk_i, .en_i(en[2]), .a_i(t2), .b_i(t1_q), .p_o(t3)
  );
  qbez_rnd_mul #(.FRAC_BITS(FRAC_BITS)) u_s3 (
    .clk_i, .en_i(en[2]), .a_i(s2), .b_i(s1_q), .p_o(s3)
  );
  qbez_rnd_mul #(.FRAC_BITS(FRAC_BITS)) u_q2 (
    .clk_i, .en_i(en[2]), .a_i(t2), .b_i(s2), .p_o(q2)
  );

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      t2p_q <= t1_q;
      s2p_q <= s1_q;
    end
  end

  // stage 3: fourth powers and the outer cross terms
  logic [W-1:0] q2p_q, t4, s4, q1, q3;

  qbez_rnd_mul #(.FRAC_BITS(FRAC_BITS)) u_t4 (
    .clk_i, .en_i(en[3]), .a_i(t3), .b_i(t2p_q), .p_o(t4)
  );
  qbez_rnd_mul #(.FRAC_BITS(FRAC_BITS)) u_s4 (
    .clk_i, .en_i(en[3]), .a_i(s3), .b_i(s2p_q), .p_o(s4)
  );
  qbez_rnd_mul #(.FRAC_BITS(FRAC_BITS)) u_q1 (
    .clk_i, .en_i(en[3]), .a_i(t2p_q), .b_i(s3), .p_o(q1)
  );
  qbez_rnd_mul #(.FRAC_BITS(FRAC_BITS)) u_q3 (
    .clk_i, .en_i(en[3]), .a_i(t3), .b_i(s2p_q), .p_o(q3)
  );

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      q2p_q <= q2;
    end
  end

  // stage 4: bernstein weights times control points
  logic [BW-1:0]          wgt [NP];
  logic signed [PW-1:0]   prod_q [NL][NP];

  always_comb begin
    wgt[0] = BW'(s4);
    wgt[1] = BW'(q1) << 2;
    wgt[2] = (BW'(q2p_q) << 2) + (BW'(q2p_q) << 1);
    wgt[3] = BW'(q3) << 2;
    wgt[4] = BW'(t4);
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int l = 0; l < NL; l++) begin
        for (int i = 0; i < NP; i++) begin
          prod_q[l][i] <=
            PW'($signed(point_q[i][(NL-1-l)*qbez_pkg::COORD_W +: qbez_pkg::COORD_W]))
            * PW'($signed({1'b0, wgt[i]}));
        end
      end
    end
  end

  // stage 5: partial sums
  logic signed [AW-1:0] psa_q [NL];
  logic signed [AW-1:0] psb_q [NL];
  logic signed [AW-1:0] psc_q [NL];

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      for (int l = 0; l < NL; l++) begin
        psa_q[l] <= AW'(prod_q[l][0]) + AW'(prod_q[l][1]);
        psb_q[l] <= AW'(prod_q[l][2]) + AW'(prod_q[l][3]);
        psc_q[l] <= AW'(prod_q[l][4]) + HALF_ACC;
      end
    end
  end

  // stage 6: final sum, round half up, saturate
  logic signed [AW-1:0]   acc [NL];
  logic signed [QW-1:0]   quo [NL];
  qbez_pkg::coord_t       sat [NL];
  qbez_pkg::coord_t       out_q [NL];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      acc[l] = psa_q[l] + psb_q[l] + psc_q[l];
      quo[l] = $signed(acc[l][AW-1:FRAC_BITS]);
      if (quo[l] > Q_MAX) begin
        sat[l] = qbez_pkg::COORD_MAX;
      end else if (quo[l] < Q_MIN) begin
        sat[l] = qbez_pkg::COORD_MIN;
      end else begin
        sat[l] = quo[l][qbez_pkg::COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      for (int l = 0; l < NL; l++) begin
        out_q[l] <= sat[l];
      end
    end
  end

  assign pt_o.x_coord = out_q[0];
  assign pt_o.y_coord = out_q[1];

  // input only stalls once every stage holds a beat
  a_no_bubble_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !t_i.ready |-> (&v_q))
    else $error("input stalled while pipeline has a bubble");

  // clamped t and s stay complementary and within one
  a_t_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> ((t0_q <= ONE) && (({1'b0, t0_q} + {1'b0, s0_q}) == {1'b0, ONE})))
    else $error("stage 0 parameter out of range");

  // a first-point write lands in the register
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_idx_i == qbez_pkg::IDX_POINT_ZERO))
      |=> (point_q[0] == $past(cfg_data_i)))
    else $error("control point write lost");

  // a held output beat does not vanish without being taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NS-1] && !pt_o.ready) |=> (v_q[NS-1] && $stable(out_q[0]) && $stable(out_q[1])))
    else $error("stalled output beat changed");

endmodule

`default_nettype wire

// ----- tb/sv/qbez_point_checker.sv -----
`default_nettype none

module qbez_point_checker #(
  parameter int FRAC_BITS = 15
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [qbez_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [qbez_pkg::POINT_W-1:0]   cfg_data_i,
  qbez_t_if                                   t_mon,
  qbez_xy_if                                  pt_mon,
  output int                                  mismatch_count_o,
  output int                                  pending_o,
  output int                                  points_checked_o
);
  import qbez_pkg::*;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } xy_pair_t;

  localparam longint unsigned T_ONE  = 64'd1 << FRAC_BITS;
  localparam longint unsigned T_HALF = 64'd1 << (FRAC_BITS - 1);

  point_t   ctrl_points [NUM_POINTS];
  xy_pair_t expected_points [$];
  xy_pair_t head_point;

  function automatic longint unsigned frac_mul(longint unsigned a, longint unsigned b);
    return (a * b + T_HALF) >> FRAC_BITS;
  endfunction

  // round half up, then clamp to the coordinate range
  function automatic coord_t round_saturate(longint acc);
    longint q;
    q = (acc + longint'(T_HALF)) >>> FRAC_BITS;
    if (q > longint'(COORD_MAX)) return COORD_MAX;
    if (q < longint'(COORD_MIN)) return COORD_MIN;
    return coord_t'(q);
  endfunction

  function automatic xy_pair_t curve_point(logic [T_W-1:0] t_raw);
    longint unsigned t, s, t2, t3, t4, s2, s3, s4;
    longint unsigned weight [NUM_POINTS];
    longint          acc_x, acc_y;
    xy_pair_t        r;
    t = t_raw;
    if (t > T_ONE) t = T_ONE;
    s  = T_ONE - t;
    t2 = frac_mul(t, t);
    t3 = frac_mul(t2, t);
    t4 = frac_mul(t3, t);
    s2 = frac_mul(s, s);
    s3 = frac_mul(s2, s);
    s4 = frac_mul(s3, s);
    weight[0] = s4;
    weight[1] = 4 * frac_mul(t, s3);
    weight[2] = 6 * frac_mul(t2, s2);
    weight[3] = 4 * frac_mul(t3, s);
    weight[4] = t4;
    acc_x = 0;
    acc_y = 0;
    for (int i = 0; i < NUM_POINTS; i++) begin
      acc_x += longint'(coord_t'(ctrl_points[i][POINT_W-1:COORD_W])) * longint'(weight[i]);
      acc_y += longint'(coord_t'(ctrl_points[i][COORD_W-1:0])) * longint'(weight[i]);
    end
    r.x = round_saturate(acc_x);
    r.y = round_saturate(acc_y);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count_o < 25) $display("[%0t] point check: %s", $time, what);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_points.delete();
      for (int i = 0; i < NUM_POINTS; i++) ctrl_points[i] = '0;
      mismatch_count_o = 0;
      pending_o        = 0;
      points_checked_o = 0;
    end else begin
      if (pt_mon.valid === 1'b1 && pt_mon.ready === 1'b1) begin
        if (expected_points.size() == 0) begin
          report_mismatch("point beat with no t beat waiting");
        end else begin
          head_point = expected_points.pop_front();
          if (pt_mon.x_coord !== head_point.x)
            report_mismatch($sformatf("x_coord got %0d want %0d", pt_mon.x_coord,
                                      head_point.x));
          if (pt_mon.y_coord !== head_point.y)
            report_mismatch($sformatf("y_coord got %0d want %0d", pt_mon.y_coord,
                                      head_point.y));
          points_checked_o++;
        end
      end
      if (t_mon.valid === 1'b1 && t_mon.ready === 1'b1)
        expected_points.push_back(curve_point(t_mon.t_value));
      // indexes past the last point are dropped
      if (cfg_we_i && cfg_idx_i < NUM_POINTS) ctrl_points[cfg_idx_i] = cfg_data_i;
      pending_o = expected_points.size();
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_quartic_bezier_point_eval.sv -----
`default_nettype none

module tb_quartic_bezier_point_eval;
  import qbez_pkg::*;

  localparam int FRAC_BITS   = 15;
  localparam int T_ONE       = 1 << FRAC_BITS;
  localparam int PHASES      = 6;
  localparam int PHASE_BEATS = 125;
  localparam int LONG_HOLD   = 80;

  typedef enum int {RX_STEADY, RX_HALF, RX_SPARSE} rx_mode_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  point_t               cfg_data;

  qbez_t_if  t_bus ();
  qbez_xy_if pt_bus ();

  int     mismatches;
  int     pending_points;
  int     points_checked;
  int     beats_sent;
  int     burst_left;
  int     gap_left;
  bit     hold_off_req;
  point_t next_points [NUM_POINTS];

  quartic_bezier_point_eval #(
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .t_i       (t_bus),
    .pt_o      (pt_bus)
  );

  qbez_point_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) u_point_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .t_mon           (t_bus),
    .pt_mon          (pt_bus),
    .mismatch_count_o(mismatches),
    .pending_o       (pending_points),
    .points_checked_o(points_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d points outstanding", pending_points);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: segments of steady, half and sparse ready, plus a long hold on request
  initial begin
    rx_mode_e mode;
    int       seg_left;
    int       hold_left;
    mode        = RX_STEADY;
    seg_left    = 0;
    hold_left   = 0;
    pt_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_left    = LONG_HOLD;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pt_bus.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(5, 60);
          case ($urandom_range(0, 2))
            0:       mode = RX_STEADY;
            1:       mode = RX_HALF;
            default: mode = RX_SPARSE;
          endcase
        end
        seg_left--;
        case (mode)
          RX_STEADY: pt_bus.ready <= 1'b1;
          RX_HALF:   pt_bus.ready <= 1'($urandom_range(0, 1));
          default:   pt_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic logic [T_W-1:0] random_t();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick < 2) return T_W'(($urandom_range(0, 1000) * T_ONE + 500) / 1000);
    if (pick == 2) return T_W'($urandom_range(T_ONE + 1, (1 << T_W) - 1));
    if (pick == 3) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return T_W'(1);
        2:       return T_W'(T_ONE - 1);
        default: return T_W'(T_ONE);
      endcase
    end
    return T_W'($urandom_range(0, T_ONE));
  endfunction

  // one t beat, with the burst and gap pattern of the sender
  task automatic send_t(input logic [T_W-1:0] tv);
    while (gap_left > 0) begin
      t_bus.valid <= 1'b0;
      gap_left--;
      @(negedge clk_i);
    end
    t_bus.valid   <= 1'b1;
    t_bus.t_value <= tv;
    do @(posedge clk_i); while (t_bus.ready !== 1'b1);
    @(negedge clk_i);
    beats_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      if ($urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(40, 100);
        gap_left   = 0;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap_left   = $urandom_range(0, 6);
      end
    end
  endtask

  task automatic wait_drained();
    t_bus.valid <= 1'b0;
    wait (pending_points == 0);
    @(negedge clk_i);
  endtask

  // loads all points, then hits the unused indexes with junk
  task automatic program_points();
    for (int i = 0; i < NUM_POINTS; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_IDX_W'(i);
      cfg_data <= next_points[i];
      @(negedge clk_i);
    end
    for (int i = NUM_POINTS; i < (1 << CFG_IDX_W); i++) begin
      cfg_idx  <= CFG_IDX_W'(i);
      cfg_data <= ($urandom_range(0, 1) == 0) ? '1 : point_t'($urandom);
      @(negedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [T_W-1:0] corner_t [10];
    corner_t = '{'0, T_W'(1), T_W'(T_ONE / 4), T_W'(T_ONE / 2), T_W'(3 * T_ONE / 4),
                 T_W'(T_ONE - 1), T_W'(T_ONE), T_W'(T_ONE + 1), 16'haaaa, '1};
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    t_bus.valid   = 1'b0;
    t_bus.t_value = '0;
    hold_off_req  = 1'b0;
    burst_left    = 0;
    gap_left      = 0;
    beats_sent    = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset points give the origin everywhere
    send_t('0);
    send_t(T_W'(T_ONE));
    send_t('1);
    wait_drained();

    next_points[0] = {COORD_MAX, COORD_MIN};
    next_points[1] = {COORD_MIN, COORD_MAX};
    next_points[2] = {16'h0000, 16'hffff};
    next_points[3] = {COORD_MAX, COORD_MAX};
    next_points[4] = {COORD_MIN, COORD_MIN};
    program_points();
    foreach (corner_t[k]) send_t(corner_t[k]);
    wait_drained();

    // all points at one extreme so rounding can overshoot
    for (int i = 0; i < NUM_POINTS; i++) next_points[i] = {COORD_MAX, COORD_MAX};
    program_points();
    for (int k = 2; k < 7; k++) send_t(corner_t[k]);
    wait_drained();
    for (int i = 0; i < NUM_POINTS; i++) next_points[i] = {COORD_MIN, COORD_MIN};
    program_points();
    for (int k = 2; k < 7; k++) send_t(corner_t[k]);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      for (int i = 0; i < NUM_POINTS; i++) begin
        if (ph == 1)
          next_points[i] = (i % 2 == 1) ? {COORD_MIN, COORD_MAX} : {COORD_MAX, COORD_MIN};
        else
          next_points[i] = point_t'($urandom);
      end
      program_points();
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (ph == 2 && n == 40) begin
          burst_left   = 3 * LONG_HOLD;
          gap_left     = 0;
          hold_off_req = 1'b1;
        end
        if (ph == 4 && n == 60) wait_drained();
        send_t(random_t());
      end
    end

    t_bus.valid <= 1'b0;
    wait (pending_points == 0);
    repeat (20) @(posedge clk_i);
    $display("covered %0d t beats and %0d checked points over %0d control point sets",
             beats_sent, points_checked, PHASES + 4);
    $display("t spanned zero, one, values above one and the 0.001 table grid");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
